// ===== hdl/rbtd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbtd_pkg
// shared types and constants of the rate budget task dispatcher
// ----------------------------------------------------------------------------
package rbtd_pkg;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] CFG_LOOP_RATE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TASK_COUNT = 1'b1;

    localparam logic [15:0] LOOP_RATE_RST = 16'd100;
    localparam logic [15:0] COUNTER_TOP   = 16'hFFFF;
    localparam logic [31:0] EPOCH_SPAN    = 32'd10;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_LOOP   = 2'd1;
    localparam logic [1:0] KIND_FINISH = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] V_DISPATCH = 2'd0;
    localparam logic [1:0] V_DONE     = 2'd1;
    localparam logic [1:0] V_STORED   = 2'd2;
    localparam logic [1:0] V_SEQ      = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  entry_index;
        logic [15:0] entry_rate;
        logic [15:0] entry_cost_limit;
        logic [15:0] budget;
        logic [15:0] run_ticks;
        logic [31:0] seconds_now;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [3:0]  task_slot;
        logic [15:0] allowed_time;
        logic [31:0] mean_time;
        logic [31:0] run_count;
        logic [31:0] overrun_count;
        logic [15:0] overrun_peak;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EPOCH,
        ST_MUL,
        ST_DIV_START,
        ST_DIV,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       take;
        logic       res_clear;
        logic       tbl_write;
        logic       loop_start;
        logic       scan_eval;
        logic       scan_hit;
        logic       scan_skip;
        logic       scan_end;
        logic       epoch_chk;
        logic       fin_read;
        logic       div_start;
        logic       fin_update;
        logic       out_load;
        logic [1:0] verdict;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       slot_ok;
        logic       scan_at_end;
        logic       scan_hit;
        logic       div_zero;
        logic       div_done;
        logic       budget_short;
    } dp_sts_t;

endpackage

// ===== hdl/rbtd_div.sv =====
// ----------------------------------------------------------------------------
// rbtd_div
// 32-bit restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rbtd_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic [31:0] quotient,
    output logic        done
);
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [32:0] shifted;
    logic [32:0] diff;

    always_comb begin
        shifted  = {rem_reg, quo_reg[31]};
        diff     = shifted - {1'b0, dvs_reg};
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = 6'd32;
        end else if (cnt_reg != 6'd0) begin
            if (!diff[32]) begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end else begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg;
    assign done     = (cnt_reg == 6'd0);
endmodule

// ===== hdl/rbtd_dp.sv =====
// ----------------------------------------------------------------------------
// rbtd_dp
// datapath: task tables, statistics stores, scan test, mean update, result beat
// ----------------------------------------------------------------------------
module rbtd_dp #(
    parameter int MAX_TASKS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  rbtd_pkg::dp_cmd_t                   cmd,
    output rbtd_pkg::dp_sts_t                   sts,
    input  rbtd_pkg::in_item_t                  s_data,
    output rbtd_pkg::out_item_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [rbtd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [rbtd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import rbtd_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam logic [6:0] MAX_T7 = 7'(MAX_TASKS);

    logic [15:0] loop_rate_reg;
    logic [4:0]  task_count_reg;
    in_item_t    in_reg;

    logic [15:0] rate_tbl [MAX_TASKS];
    logic [15:0] cost_tbl [MAX_TASKS];
    logic [15:0] mark_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] mark_vld_reg;
    logic [31:0] mean_mem [MAX_TASKS];
    logic [31:0] runs_mem [MAX_TASKS];
    logic [31:0] ovr_mem  [MAX_TASKS];
    logic [15:0] peak_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] stat_vld_reg;

    logic [15:0]        loop_cnt_reg;
    logic [CNT_W-1:0]   scan_pos_reg;
    logic signed [17:0] rem_reg;
    logic [31:0]        epoch_reg;

    logic [32:0] sc_prod_reg;
    logic [15:0] sc_dt_reg;
    logic        sc_rzero_reg;
    logic [15:0] sc_cost_reg;

    logic [31:0] f_mean_reg, f_runs_reg, f_ovr_reg, f_prod_reg;
    logic [15:0] f_peak_reg, f_cost_reg;

    logic [3:0]  res_slot_reg;
    logic [15:0] res_allowed_reg;
    logic [31:0] res_mean_reg, res_runs_reg, res_ovr_reg;
    logic [15:0] res_peak_reg;
    out_item_t   m_data_reg;

    logic [CNT_W-1:0]   limit;
    logic [IDX_W-1:0]   idx;
    logic [CNT_W-1:0]   fin_pos;
    logic [IDX_W-1:0]   fin_idx;
    logic [IDX_W-1:0]   ld_idx;
    logic [15:0]        mark_rd;
    logic [15:0]        dt;
    logic [32:0]        prod_next;
    logic               due;
    logic               fits;
    logic signed [17:0] rem_after;
    logic [31:0]        div_quo;
    logic               div_done;
    logic [31:0]        runs_inc;
    logic [31:0]        mean_new;
    logic               overrun;

    always_comb begin
        if ({2'b00, task_count_reg} >= MAX_T7) begin
            limit = CNT_W'(MAX_TASKS);
        end else begin
            limit = CNT_W'(task_count_reg);
        end
        idx       = scan_pos_reg[IDX_W-1:0];
        fin_pos   = scan_pos_reg - CNT_W'(1);
        fin_idx   = fin_pos[IDX_W-1:0];
        ld_idx    = IDX_W'(in_reg.entry_index);
        mark_rd   = mark_vld_reg[idx] ? mark_mem[idx] : 16'd0;
        dt        = loop_cnt_reg - mark_rd;
        prod_next = 33'({1'b0, dt} + 17'd1) * 33'(rate_tbl[idx]);
        due       = sc_rzero_reg ? (sc_dt_reg == COUNTER_TOP)
                                 : ((sc_dt_reg != 16'd0) && (33'(loop_rate_reg) < sc_prod_reg));
        fits      = $signed({2'b00, sc_cost_reg}) < rem_reg;
        rem_after = rem_reg - $signed({2'b00, in_reg.run_ticks});
        runs_inc  = f_runs_reg + 32'd1;
        mean_new  = (runs_inc == 32'd0) ? f_mean_reg : div_quo;
        overrun   = (in_reg.run_ticks > f_cost_reg);
    end

    rbtd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (f_prod_reg + 32'(in_reg.run_ticks)),
        .divisor  (runs_inc),
        .quotient (div_quo),
        .done     (div_done)
    );

    always_comb begin
        sts.kind         = in_reg.kind;
        sts.slot_ok      = ({3'b000, in_reg.entry_index} < MAX_T7);
        sts.scan_at_end  = (scan_pos_reg >= limit);
        sts.scan_hit     = due && fits;
        sts.div_zero     = (runs_inc == 32'd0);
        sts.div_done     = div_done;
        sts.budget_short = rem_after < 0;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_rate_reg  <= LOOP_RATE_RST;
            task_count_reg <= '0;
            mark_vld_reg   <= '0;
            stat_vld_reg   <= '0;
            loop_cnt_reg   <= '0;
            scan_pos_reg   <= '0;
            rem_reg        <= '0;
            epoch_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_LOOP_RATE:  loop_rate_reg  <= cfg_wdata;
                    CFG_TASK_COUNT: task_count_reg <= cfg_wdata[4:0];
                    default: ;
                endcase
            end
            if (cmd.loop_start) begin
                if (loop_cnt_reg == COUNTER_TOP) begin
                    loop_cnt_reg <= '0;
                    mark_vld_reg <= '0;
                end else begin
                    loop_cnt_reg <= loop_cnt_reg + 16'd1;
                end
                rem_reg      <= $signed({2'b00, in_reg.budget});
                scan_pos_reg <= '0;
            end
            if (cmd.scan_hit) begin
                mark_vld_reg[idx] <= 1'b1;
                scan_pos_reg      <= scan_pos_reg + CNT_W'(1);
            end
            if (cmd.scan_skip) begin
                scan_pos_reg <= scan_pos_reg + CNT_W'(1);
            end
            if (cmd.scan_end) begin
                scan_pos_reg <= limit;
            end
            if (cmd.epoch_chk && (in_reg.seconds_now > epoch_reg + EPOCH_SPAN)) begin
                stat_vld_reg <= '0;
                epoch_reg    <= in_reg.seconds_now;
            end
            if (cmd.fin_update) begin
                stat_vld_reg[fin_idx] <= 1'b1;
                rem_reg               <= rem_after;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            in_reg <= s_data;
        end
        if (cmd.tbl_write) begin
            rate_tbl[ld_idx] <= in_reg.entry_rate;
            cost_tbl[ld_idx] <= in_reg.entry_cost_limit;
        end
        if (cmd.res_clear) begin
            res_slot_reg    <= cmd.tbl_write ? in_reg.entry_index : 4'd0;
            res_allowed_reg <= '0;
            res_mean_reg    <= '0;
            res_runs_reg    <= '0;
            res_ovr_reg     <= '0;
            res_peak_reg    <= '0;
        end
        if (cmd.scan_eval) begin
            sc_prod_reg  <= prod_next;
            sc_dt_reg    <= dt;
            sc_rzero_reg <= (rate_tbl[idx] == 16'd0);
            sc_cost_reg  <= cost_tbl[idx];
        end
        if (cmd.scan_hit) begin
            mark_mem[idx]   <= loop_cnt_reg;
            res_slot_reg    <= 4'(idx);
            res_allowed_reg <= sc_cost_reg;
        end
        if (cmd.fin_read) begin
            f_mean_reg <= stat_vld_reg[fin_idx] ? mean_mem[fin_idx] : 32'd0;
            f_runs_reg <= stat_vld_reg[fin_idx] ? runs_mem[fin_idx] : 32'd0;
            f_ovr_reg  <= stat_vld_reg[fin_idx] ? ovr_mem[fin_idx]  : 32'd0;
            f_peak_reg <= stat_vld_reg[fin_idx] ? peak_mem[fin_idx] : 16'd0;
            f_prod_reg <= 32'((stat_vld_reg[fin_idx] ? mean_mem[fin_idx] : 32'd0)
                            * (stat_vld_reg[fin_idx] ? runs_mem[fin_idx] : 32'd0));
            f_cost_reg <= cost_tbl[fin_idx];
        end
        if (cmd.fin_update) begin
            mean_mem[fin_idx] <= mean_new;
            runs_mem[fin_idx] <= runs_inc;
            ovr_mem[fin_idx]  <= overrun ? f_ovr_reg + 32'd1 : f_ovr_reg;
            peak_mem[fin_idx] <= (overrun && in_reg.run_ticks > f_peak_reg)
                                 ? in_reg.run_ticks : f_peak_reg;
            res_slot_reg      <= 4'(fin_idx);
            res_mean_reg      <= mean_new;
            res_runs_reg      <= runs_inc;
            res_ovr_reg       <= overrun ? f_ovr_reg + 32'd1 : f_ovr_reg;
            res_peak_reg      <= (overrun && in_reg.run_ticks > f_peak_reg)
                                 ? in_reg.run_ticks : f_peak_reg;
        end
        if (cmd.out_load) begin
            m_data_reg.verdict       <= cmd.verdict;
            m_data_reg.task_slot     <= res_slot_reg;
            m_data_reg.allowed_time  <= res_allowed_reg;
            m_data_reg.mean_time     <= res_mean_reg;
            m_data_reg.run_count     <= res_runs_reg;
            m_data_reg.overrun_count <= res_ovr_reg;
            m_data_reg.overrun_peak  <= res_peak_reg;
        end
    end

    assign m_data = m_data_reg;
endmodule

// ===== hdl/rbtd_ctrl.sv =====
// ----------------------------------------------------------------------------
// rbtd_ctrl
// controller: item decode, scan sequencing, finish handling, result beat
// ----------------------------------------------------------------------------
module rbtd_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output rbtd_pkg::dp_cmd_t  cmd,
    input  rbtd_pkg::dp_sts_t  sts
);
    import rbtd_pkg::*;

    state_t     state_reg, state_next;
    logic       await_reg, await_next;
    logic [1:0] verdict_reg, verdict_next;
    logic       m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            await_reg   <= 1'b0;
            verdict_reg <= V_SEQ;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            await_reg   <= await_next;
            verdict_reg <= verdict_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        await_next   = await_reg;
        verdict_next = verdict_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.verdict  = verdict_reg;
        s_ready      = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.res_clear = 1'b1;
                verdict_next  = V_SEQ;
                state_next    = ST_EMIT;
                case (sts.kind)
                    KIND_LOAD: begin
                        if (!await_reg && sts.slot_ok) begin
                            cmd.tbl_write = 1'b1;
                            verdict_next  = V_STORED;
                        end
                    end
                    KIND_LOOP: begin
                        if (!await_reg) begin
                            cmd.loop_start = 1'b1;
                            state_next     = ST_SCAN_RD;
                        end
                    end
                    KIND_FINISH: begin
                        if (await_reg) begin
                            state_next = ST_EPOCH;
                        end
                    end
                    default: ;
                endcase
            end
            ST_SCAN_RD: begin
                if (sts.scan_at_end) begin
                    cmd.scan_end = 1'b1;
                    await_next   = 1'b0;
                    verdict_next = V_DONE;
                    state_next   = ST_EMIT;
                end else begin
                    cmd.scan_eval = 1'b1;
                    state_next    = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK: begin
                if (sts.scan_hit) begin
                    cmd.scan_hit = 1'b1;
                    await_next   = 1'b1;
                    verdict_next = V_DISPATCH;
                    state_next   = ST_EMIT;
                end else begin
                    cmd.scan_skip = 1'b1;
                    state_next    = ST_SCAN_RD;
                end
            end
            ST_EPOCH: begin
                cmd.epoch_chk = 1'b1;
                state_next    = ST_MUL;
            end
            ST_MUL: begin
                cmd.fin_read = 1'b1;
                state_next   = ST_DIV_START;
            end
            ST_DIV_START: begin
                if (sts.div_zero) begin
                    state_next = ST_UPDATE;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.fin_update = 1'b1;
                if (sts.budget_short) begin
                    await_next   = 1'b0;
                    verdict_next = V_DONE;
                    state_next   = ST_EMIT;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
endmodule

// ===== hdl/rate_budget_task_dispatcher.sv =====
// ----------------------------------------------------------------------------
// rate_budget_task_dispatcher
// cooperative rate scheduler with a per-loop time budget
//
// input channel s_*: one beat per item (load entry, loop start, task finished)
// result channel m_*: exactly one result beat per input beat, in order
// cfg_*: loop_rate (index 0) and task_count (index 1), to be written by the user
// only when idle; the block itself does not enforce it
// one item is worked on at a time; s_ready is high only while idle
// load and out-of-sequence items go straight from decode to the result beat
// loop start: entries are read and checked in turn until one is dispatched or
// the scan runs off the table
// task finished: epoch check, statistics read, mean divider (skipped when
// the run count wraps) and update; a result beat follows when the budget runs
// out, else the scan resumes up to a dispatch or the table end
// s_ready returns in the cycle after the result is written
// a single output register holds the result; a new item is taken while it
// waits, and the block stalls before writing the next result until it is taken
// reset: loop_rate 100, task_count 0, statistics and last-run marks zero,
// loop counter zero, not waiting for a finish; tables hold nothing valid
// ----------------------------------------------------------------------------
module rate_budget_task_dispatcher #(
    parameter int MAX_TASKS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  rbtd_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output rbtd_pkg::out_item_t                 m_data,
    input  logic                                cfg_wr_en,
    input  logic [rbtd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [rbtd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import rbtd_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    rbtd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    rbtd_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_data    (s_data),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );
endmodule

// ===== hdl/rbtd_checker.sv =====
// ----------------------------------------------------------------------------
// rbtd_checker
// port-level checks of the dispatcher, bound to the top level
// ----------------------------------------------------------------------------
module rbtd_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input rbtd_pkg::out_item_t m_data
);
    import rbtd_pkg::*;

    // result beat holds while stalled
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one item at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("item taken while busy");

    a_seq_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.verdict == V_SEQ |->
            m_data.task_slot == 4'd0 && m_data.allowed_time == 16'd0 &&
            m_data.mean_time == 32'd0 && m_data.run_count == 32'd0 &&
            m_data.overrun_count == 32'd0 && m_data.overrun_peak == 16'd0)
        else $error("out-of-sequence beat carries data");

    a_stored_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.verdict == V_STORED |->
            m_data.allowed_time == 16'd0 && m_data.run_count == 32'd0 &&
            m_data.mean_time == 32'd0)
        else $error("stored beat carries statistics");
endmodule

bind rate_budget_task_dispatcher rbtd_checker u_rbtd_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
